@@ hdl/psl_pkg.sv @@
// Package for the priority sorted list: operation codes and the word types
// shared by the slot cell and the top level. No dependencies.
package psl_pkg;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;  // unused code, no effect

    // Input word
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] entry_tag;
        logic [7:0] entry_priority;
        logic [3:0] read_position;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [4:0] entry_count;
        logic       op_success;
        logic [7:0] read_tag;
        logic [7:0] read_key;
    } t_out_word;

    // One stored entry
    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] key;
    } t_entry;

    // Command broadcast to every cell
    typedef struct packed {
        logic       en;
        logic       ins;
        logic       rem;
        logic [7:0] tag;
        logic [7:0] key;
    } t_cell_ctl;

    // Status a cell hands to its right-hand neighbor
    typedef struct packed {
        logic stay;      // entry sorts at or before the new key
        logic hit_thru;  // tag matched here or in an earlier cell
    } t_cell_stat;

endpackage

@@ hdl/psl_cell.sv @@
// One slot of the priority sorted list: holds a tag and key, compares them
// against the broadcast command and shifts to/from its neighbors. Uses psl_pkg.
module psl_cell
    import psl_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_valid,     // slot lies below the count
    input  t_entry     i_left,
    input  t_cell_stat i_left_stat,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output t_cell_stat o_stat
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_hit;

    // Local compares
    assign w_hit              = i_valid && (r_entry.tag == i_ctl.tag);
    assign o_stat.stay        = i_valid && !(i_ctl.key < r_entry.key);
    assign o_stat.hit_thru    = i_left_stat.hit_thru || w_hit;
    assign o_entry            = r_entry;

    // Next slot contents: insert shifts right, remove shifts left
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (!o_stat.stay) begin
                if (i_left_stat.stay) begin
                    n_entry.tag = i_ctl.tag;
                    n_entry.key = i_ctl.key;
                end else begin
                    n_entry = i_left;
                end
            end
        end else if (i_ctl.rem) begin
            if (o_stat.hit_thru) begin
                n_entry = i_right;
            end
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_entry <= n_entry;
        end
    end

endmodule

@@ hdl/priority_sorted_list.sv @@
// priority_sorted_list: sorted list of up to DEPTH tagged entries as a row of slot cells.
// The result of an accepted word appears in the output register in the next cycle.
// Throughput: one word per cycle; every operation is one parallel compare-and-shift
// of the cell row; input stalls only while a result word waits on a stalled output.
// Reset clears the count and the output valid; slot contents are not cleared.
// Uses psl_pkg and psl_cell.
module priority_sorted_list
    import psl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_word     r_out_word;
    t_out_word     n_out_word;

    logic          w_accept;
    t_cell_ctl     w_ctl;
    t_entry        w_entry [DEPTH];
    t_cell_stat    w_stat  [DEPTH];
    logic [CW+4:0] w_count_ext;
    logic [CW+4:0] w_rpos_ext;
    logic          w_read_ok;
    logic          w_ins_ok;
    logic          w_rem_ok;

    // Handshake
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Command broadcast
    assign w_ctl.en  = w_accept;
    assign w_ctl.ins = (i_in_word.operation == OP_INSERT);
    assign w_ctl.rem = (i_in_word.operation == OP_REMOVE);
    assign w_ctl.tag = i_in_word.entry_tag;
    assign w_ctl.key = i_in_word.entry_priority;

    // Row of slot cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_entry     w_left;
        t_cell_stat w_left_stat;
        t_entry     w_right;
        logic       w_valid;

        assign w_valid = (CW'(gi) < r_count);
        if (gi == 0) begin : g_first
            assign w_left               = '0;
            assign w_left_stat.stay     = 1'b1;
            assign w_left_stat.hit_thru = 1'b0;
        end else begin : g_mid
            assign w_left      = w_entry[gi-1];
            assign w_left_stat = w_stat[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_right = w_entry[gi];
        end else begin : g_inner
            assign w_right = w_entry[gi+1];
        end

        psl_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_valid     (w_valid),
            .i_left      (w_left),
            .i_left_stat (w_left_stat),
            .i_right     (w_right),
            .o_entry     (w_entry[gi]),
            .o_stat      (w_stat[gi])
        );
    end

    // Outcome of the operation
    assign w_ins_ok    = !w_stat[DEPTH-1].stay;
    assign w_rem_ok    = w_stat[DEPTH-1].hit_thru;
    assign w_rpos_ext  = (CW+5)'(i_in_word.read_position);
    assign w_read_ok   = (w_rpos_ext < (CW+5)'(r_count)) &&
                         (w_rpos_ext < (CW+5)'(DEPTH));

    always_comb begin
        n_count    = r_count;
        n_out_word = '0;
        unique case (i_in_word.operation)
            OP_INSERT: begin
                n_out_word.op_success = w_ins_ok;
                if (w_ins_ok && (r_count != CW'(DEPTH))) begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                n_out_word.op_success = w_rem_ok;
                if (w_rem_ok) begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_READ: begin
                n_out_word.op_success = w_read_ok;
                if (w_read_ok) begin
                    n_out_word.read_tag = w_entry[w_rpos_ext[IW-1:0]].tag;
                    n_out_word.read_key = w_entry[w_rpos_ext[IW-1:0]].key;
                end
            end
            default: begin
                n_out_word.op_success = 1'b0;
            end
        endcase
        w_count_ext            = (CW+5)'(n_count);
        n_out_word.entry_count = w_count_ext[4:0];
    end

    // Count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("entry count changed without an accepted word");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.op_success) |->
        (r_out_word.read_tag == 8'd0 && r_out_word.read_key == 8'd0))
        else $error("failed operation returned read data");
`endif

endmodule
